[hdl/cap_pkg.sv]
package cap_pkg;

  localparam int TABLE_DEPTH_DEF     = 4096;
  localparam int BYTES_PER_ENTRY_DEF = 4;

  localparam int ADDR_W  = 32;
  localparam int INDEX_W = 12;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [ADDR_W-1:0] ADDR_SKEW = 32'h0000_000B;

  typedef enum logic [1:0] {
    REQ_CALL     = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_RD_ARC   = 2'd2,
    REQ_RD_HIST  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_ENABLE  = 2'd0,
    REG_LOW_PC  = 2'd1,
    REG_HIGH_PC = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
  } cap_cfg_t;

  typedef struct packed {
    logic clr;
    logic cap;
    logic calc;
    logic mul;
    logic rd;
    logic wr;
  } cap_cmd_t;

  typedef struct packed {
    logic clr_last;
  } cap_sts_t;

  function automatic logic [ADDR_W-1:0] sat_inc(input logic [ADDR_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

[hdl/cap_ram.sv]
module cap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/cap_regs.sv]
module cap_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cap_pkg::PADDR_W-1:0]  paddr,
  input  logic [cap_pkg::PDATA_W-1:0]  pwdata,
  output logic [cap_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output cap_pkg::cap_cfg_t            cfg
);
  import cap_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLE:  cfg.en   <= pwdata[0];
        REG_LOW_PC:  cfg.low  <= pwdata;
        REG_HIGH_PC: cfg.high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:  prdata = {{(PDATA_W-1){1'b0}}, cfg.en};
      REG_LOW_PC:  prdata = cfg.low;
      REG_HIGH_PC: prdata = cfg.high;
      default:     prdata = '0;
    endcase
  end

endmodule

[hdl/cap_ctrl.sv]
module cap_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cap_pkg::cap_sts_t sts,
  output cap_pkg::cap_cmd_t cmd
);
  import cap_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CALC  = 6'b000100,
    S_MUL   = 6'b001000,
    S_RD    = 6'b010000,
    S_WR    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.cap    = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_item_seq: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 (state == S_WR))
    else $error("item did not reach write-back four cycles after accept");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (state != S_CLEAR))
    else $error("clearing pass re-entered without reset");

endmodule

[hdl/cap_dp.sv]
module cap_dp #(
  parameter int TABLE_DEPTH     = cap_pkg::TABLE_DEPTH_DEF,
  parameter int BYTES_PER_ENTRY = cap_pkg::BYTES_PER_ENTRY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cap_pkg::cap_cmd_t            cmd,
  output cap_pkg::cap_sts_t            sts,
  input  cap_pkg::cap_cfg_t            cfg,
  input  logic [1:0]                   req_type,
  input  logic [cap_pkg::ADDR_W-1:0]   caller_addr,
  input  logic [cap_pkg::ADDR_W-1:0]   callee_addr,
  input  logic [cap_pkg::INDEX_W-1:0]  entry_index,
  output logic                         done,
  output logic                         recorded,
  output logic [cap_pkg::ADDR_W-1:0]   arc_caller,
  output logic [cap_pkg::ADDR_W-1:0]   arc_callee,
  output logic [cap_pkg::ADDR_W-1:0]   arc_count,
  output logic [cap_pkg::ADDR_W-1:0]   hist_count
);
  import cap_pkg::*;

  localparam int    IDX_W = $clog2(TABLE_DEPTH);
  localparam longint SPAN = longint'(TABLE_DEPTH) * BYTES_PER_ENTRY;
  localparam int    D_W   = $clog2(SPAN);
  localparam int    SH    = D_W + $clog2(BYTES_PER_ENTRY);
  localparam longint RECIP = ((longint'(1) <<< SH) + BYTES_PER_ENTRY - 1) / BYTES_PER_ENTRY;
  localparam int    M_W   = SH + 1;
  localparam int    P_W   = D_W + M_W;
  localparam logic [ADDR_W-1:0] SPAN_W  = ADDR_W'(SPAN);
  localparam logic [ADDR_W-1:0] DEPTH_W = ADDR_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_E  = IDX_W'(TABLE_DEPTH - 1);

  req_t              req;
  logic [ADDR_W-1:0] from_a, self_a, last_pc;
  logic [INDEX_W-1:0] idx;
  logic              hit, in_tab;
  logic [D_W-1:0]    d;
  logic [IDX_W-1:0]  e, clr_cnt;

  logic [ADDR_W-1:0] a, diff;
  logic              is_upd, in_win;
  logic [P_W-1:0]    prod;

  logic [IDX_W-1:0]  waddr;
  logic              we_arc, we_hist, upd_ok;
  logic [ADDR_W-1:0] q_caller, q_callee, q_count, q_hist;
  logic [ADDR_W-1:0] w_caller, w_callee, w_count, w_hist;

  assign is_upd = (req == REQ_CALL) || (req == REQ_TICK);
  assign a      = (req == REQ_CALL) ? from_a : last_pc;
  assign in_win = (a >= cfg.low) && (a <= cfg.high);
  assign diff   = a - cfg.low;
  assign prod   = P_W'(d) * P_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req    <= req_t'(req_type);
      from_a <= caller_addr - ADDR_SKEW;
      self_a <= callee_addr - ADDR_SKEW;
      idx    <= entry_index;
    end
    if (cmd.calc) begin
      hit    <= cfg.en & is_upd & in_win;
      in_tab <= is_upd ? (diff < SPAN_W) : (ADDR_W'(idx) < DEPTH_W);
      d      <= diff[D_W-1:0];
    end
    if (cmd.mul) begin
      e <= is_upd ? prod[SH +: IDX_W] : IDX_W'(idx);
    end
  end

  assign upd_ok  = cmd.wr & hit & in_tab;
  assign we_arc  = cmd.clr | (upd_ok & (req == REQ_CALL));
  assign we_hist = cmd.clr | (upd_ok & (req == REQ_TICK));
  assign waddr   = cmd.clr ? clr_cnt : e;
  assign w_caller = cmd.clr ? '0 : from_a;
  assign w_callee = cmd.clr ? '0 : self_a;
  assign w_count  = cmd.clr ? '0 : sat_inc(q_count);
  assign w_hist   = cmd.clr ? '0 : sat_inc(q_hist);

  cap_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_caller (
    .clk, .we(we_arc), .waddr, .wdata(w_caller), .re(cmd.rd), .raddr(e), .rdata(q_caller)
  );
  cap_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_callee (
    .clk, .we(we_arc), .waddr, .wdata(w_callee), .re(cmd.rd), .raddr(e), .rdata(q_callee)
  );
  cap_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_count (
    .clk, .we(we_arc), .waddr, .wdata(w_count), .re(cmd.rd), .raddr(e), .rdata(q_count)
  );
  cap_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_hist (
    .clk, .we(we_hist), .waddr, .wdata(w_hist), .re(cmd.rd), .raddr(e), .rdata(q_hist)
  );

  assign sts.clr_last = (clr_cnt == LAST_E);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      last_pc <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.wr;
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.wr && hit && (req == REQ_CALL)) begin
        last_pc <= self_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      recorded   <= hit & in_tab;
      arc_caller <= (req == REQ_RD_ARC && in_tab) ? q_caller : '0;
      arc_callee <= (req == REQ_RD_ARC && in_tab) ? q_callee : '0;
      arc_count  <= (req == REQ_RD_ARC && in_tab) ? q_count : '0;
      hist_count <= (req == REQ_RD_HIST && in_tab) ? q_hist : '0;
    end
  end

  a_done_after_rd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.rd, 2))
    else $error("result strobe without a table read two cycles earlier");

  a_rec_fields: assert property (@(posedge clk) disable iff (rst)
    (done && recorded) |-> (arc_count == '0 && hist_count == '0))
    else $error("update result carries read data");

endmodule

[hdl/call_arc_and_pc_histogram_profiler.sv]
// channel   handshake                          payload
// input     start, busy (taken: start & !busy) req_type caller_addr callee_addr entry_index
// result    done (one-cycle strobe)            recorded arc_caller arc_callee arc_count hist_count
// config    APB psel/penable/pwrite, pready=1  paddr pwdata prdata
//
// An item passes from accept to the done strobe through window check, index
// multiply, table read and write-back. A new item is taken in the cycle done is high,
// so the block takes no new item before the last one is written back.
// After reset a clearing pass writes zero into all tables, one entry a cycle,
// with busy high; config writes are taken meanwhile.
// The receiver cannot stall: each result is shown for one cycle only.
module call_arc_and_pc_histogram_profiler #(
  parameter int TABLE_DEPTH     = cap_pkg::TABLE_DEPTH_DEF,
  parameter int BYTES_PER_ENTRY = cap_pkg::BYTES_PER_ENTRY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [cap_pkg::ADDR_W-1:0]   caller_addr,
  input  logic [cap_pkg::ADDR_W-1:0]   callee_addr,
  input  logic [cap_pkg::INDEX_W-1:0]  entry_index,
  output logic                         done,
  output logic                         recorded,
  output logic [cap_pkg::ADDR_W-1:0]   arc_caller,
  output logic [cap_pkg::ADDR_W-1:0]   arc_callee,
  output logic [cap_pkg::ADDR_W-1:0]   arc_count,
  output logic [cap_pkg::ADDR_W-1:0]   hist_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cap_pkg::PADDR_W-1:0]  paddr,
  input  logic [cap_pkg::PDATA_W-1:0]  pwdata,
  output logic [cap_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import cap_pkg::*;

  cap_cfg_t cfg;
  cap_cmd_t cmd;
  cap_sts_t sts;

  cap_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cap_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .sts, .cmd
  );

  cap_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .BYTES_PER_ENTRY(BYTES_PER_ENTRY)
  ) u_dp (
    .clk, .rst, .cmd, .sts, .cfg,
    .req_type, .caller_addr, .callee_addr, .entry_index,
    .done, .recorded, .arc_caller, .arc_callee, .arc_count, .hist_count
  );

endmodule

[dv/tb_top.sv]
module tb_top;
  import cap_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int STEP        = BYTES_PER_ENTRY_DEF;
  localparam int IDLE_LIMIT  = 20000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 56;

  typedef struct packed {
    logic              rec;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] cnt;
    logic [ADDR_W-1:0] hist;
  } prof_out_t;

  typedef struct {
    bit                 cfg;
    req_t               kind;
    logic [ADDR_W-1:0]  a;
    logic [ADDR_W-1:0]  b;
    logic [INDEX_W-1:0] idx;
    bit                 pinned;
    prof_out_t          want;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               req_type;
  logic [ADDR_W-1:0]  caller_addr;
  logic [ADDR_W-1:0]  callee_addr;
  logic [INDEX_W-1:0] entry_index;
  logic               done;
  logic               recorded;
  logic [ADDR_W-1:0]  arc_caller;
  logic [ADDR_W-1:0]  arc_callee;
  logic [ADDR_W-1:0]  arc_count;
  logic [ADDR_W-1:0]  hist_count;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  call_arc_and_pc_histogram_profiler u_dut (.*);

  // profiler state as the testbench sees it
  bit [ADDR_W-1:0] arc_src_tbl  [DEPTH];
  bit [ADDR_W-1:0] arc_dst_tbl  [DEPTH];
  bit [ADDR_W-1:0] arc_hits_tbl [DEPTH];
  bit [ADDR_W-1:0] pc_hist_tbl  [DEPTH];
  bit [ADDR_W-1:0] cur_pc;
  bit              cfg_en;
  bit [ADDR_W-1:0] cfg_low;
  bit [ADDR_W-1:0] cfg_high;

  prof_out_t pending_results[$];
  plan_row_t plan[$];
  int        hot_idx[$];

  bit        pin_valid;
  prof_out_t pin_res;
  bit        burst;

  int mismatches;
  int n_kind[4];
  int n_recorded;
  int n_reg_writes;
  int n_windows;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit in_text(logic [ADDR_W-1:0] addr);
    return addr >= cfg_low && addr <= cfg_high;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(logic [ADDR_W-1:0] addr);
    return (addr - cfg_low) / STEP;
  endfunction

  function automatic logic [ADDR_W-1:0] bump(logic [ADDR_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic prof_out_t profile_step(req_t kind, logic [ADDR_W-1:0] caller,
                                             logic [ADDR_W-1:0] callee,
                                             logic [INDEX_W-1:0] idx);
    prof_out_t       r;
    logic [ADDR_W-1:0] from;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] slot;
    r = '0;
    case (kind)
      REQ_CALL: begin
        if (cfg_en) begin
          from = caller - ADDR_SKEW;
          dest = callee - ADDR_SKEW;
          if (in_text(from)) begin
            slot   = slot_of(from);
            cur_pc = dest;
            if (slot < 32'(DEPTH)) begin
              arc_src_tbl[slot]  = from;
              arc_dst_tbl[slot]  = dest;
              arc_hits_tbl[slot] = bump(arc_hits_tbl[slot]);
              r.rec = 1'b1;
            end
          end
        end
      end
      REQ_TICK: begin
        if (cfg_en && in_text(cur_pc)) begin
          slot = slot_of(cur_pc);
          if (slot < 32'(DEPTH)) begin
            pc_hist_tbl[slot] = bump(pc_hist_tbl[slot]);
            r.rec = 1'b1;
          end
        end
      end
      REQ_RD_ARC: begin
        r.src = arc_src_tbl[idx];
        r.dst = arc_dst_tbl[idx];
        r.cnt = arc_hits_tbl[idx];
      end
      default: r.hist = pc_hist_tbl[idx];
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    mismatches++;
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
  endtask

  task automatic check_field(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  always @(posedge clk) begin : scoreboard
    prof_out_t e;
    prof_out_t p;
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item pending", '0, '0);
        end else begin
          e = pending_results.pop_front();
          check_field("recorded", {31'b0, e.rec}, {31'b0, recorded});
          check_field("arc_caller", e.src, arc_caller);
          check_field("arc_callee", e.dst, arc_callee);
          check_field("arc_count", e.cnt, arc_count);
          check_field("hist_count", e.hist, hist_count);
        end
      end
      if (start && busy === 1'b0) begin
        p = profile_step(req_type, caller_addr, callee_addr, entry_index);
        if (pin_valid) p = pin_res;
        pending_results.push_back(p);
        n_kind[req_type]++;
        if (p.rec) n_recorded++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1 || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t r, logic [PDATA_W-1:0] v);
    logic [PDATA_W-1:0] want;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(int'(r) * 4);
    pwdata  = v;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    case (r)
      REG_ENABLE: cfg_en  = v[0];
      REG_LOW_PC: cfg_low = v;
      default:    cfg_high = v;
    endcase
    n_reg_writes++;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    case (r)
      REG_ENABLE: want = {31'b0, cfg_en};
      REG_LOW_PC: want = cfg_low;
      default:    want = cfg_high;
    endcase
    check_field("register readback", want, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_window(bit en, logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    wait_drained();
    reg_write(REG_ENABLE, {31'b0, en});
    reg_write(REG_LOW_PC, lo);
    reg_write(REG_HIGH_PC, hi);
    n_windows++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(req_t k, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                           logic [INDEX_W-1:0] i, bit pinned, prof_out_t want);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type    = k;
    caller_addr = a;
    callee_addr = b;
    entry_index = i;
    pin_valid   = pinned;
    pin_res     = want;
    start       = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_text_addr();
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] reach;
    if (cfg_low > cfg_high) return $urandom;
    span  = cfg_high - cfg_low;
    reach = (span > 32'(STEP * (DEPTH + 64))) ? 32'(STEP * (DEPTH + 64)) : span;
    if ($urandom_range(0, 7) == 0) reach = span;
    if (reach == '1) return cfg_low + $urandom;
    return cfg_low + $urandom_range(0, reach);
  endfunction

  function automatic void note_slot(logic [ADDR_W-1:0] addr);
    if (in_text(addr) && slot_of(addr) < 32'(DEPTH)) begin
      hot_idx.push_back(int'(slot_of(addr)));
      if (hot_idx.size() > 64) void'(hot_idx.pop_front());
    end
  endfunction

  task automatic make_random_item(output req_t k, output logic [ADDR_W-1:0] a,
                                  output logic [ADDR_W-1:0] b, output logic [INDEX_W-1:0] i);
    int                roll;
    logic [ADDR_W-1:0] from;
    logic [ADDR_W-1:0] dest;
    a    = $urandom;
    b    = $urandom;
    i    = INDEX_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      k = req_t'(2'($urandom));
      return;
    end
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      k    = REQ_CALL;
      from = pick_text_addr();
      dest = ($urandom_range(0, 9) < 7) ? pick_text_addr() : $urandom;
      a    = from + ADDR_SKEW;
      b    = dest + ADDR_SKEW;
      note_slot(from);
      note_slot(dest);
    end else if (roll < 70) begin
      k = REQ_TICK;
    end else begin
      k = (roll < 85) ? REQ_RD_ARC : REQ_RD_HIST;
      if (hot_idx.size() > 0 && $urandom_range(0, 3) != 0)
        i = INDEX_W'(hot_idx[$urandom_range(0, hot_idx.size() - 1)]);
    end
  endtask

  function automatic void add_item(req_t k, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                                   logic [INDEX_W-1:0] i, bit pinned, prof_out_t want);
    plan_row_t r;
    r.cfg    = 1'b0;
    r.kind   = k;
    r.a      = a;
    r.b      = b;
    r.idx    = i;
    r.pinned = pinned;
    r.want   = want;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(bit en, logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    plan_row_t r;
    r.cfg    = 1'b1;
    r.kind   = REQ_CALL;
    r.a      = lo;
    r.b      = hi;
    r.idx    = {11'b0, en};
    r.pinned = 1'b0;
    r.want   = '0;
    plan.push_back(r);
  endfunction

  initial begin : stimulus
    int                 ph;
    int                 n;
    req_t               k;
    logic [ADDR_W-1:0]  a;
    logic [ADDR_W-1:0]  b;
    logic [INDEX_W-1:0] i;
    logic [ADDR_W-1:0]  lo;
    logic [ADDR_W-1:0]  hi;
    bit                 en;

    rst         = 1'b1;
    start       = 1'b0;
    req_type    = REQ_CALL;
    caller_addr = '0;
    callee_addr = '0;
    entry_index = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    pin_valid   = 1'b0;
    pin_res     = '0;
    burst       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // tables clear after reset, profiling off
    add_item(REQ_RD_ARC,  32'h0, 32'h0, 12'h000, 1'b1, '0);
    add_item(REQ_RD_HIST, 32'h0, 32'h0, 12'hFFF, 1'b1, '0);
    add_item(REQ_CALL, 32'h0000_100B, 32'h0000_102B, 12'h0, 1'b1, '0);
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b1, '0);
    // window wider than the table
    add_cfg(1'b1, 32'h0000_1000, 32'h0000_50FF);
    add_item(REQ_CALL, 32'h0000_100B, 32'h0000_102B, 12'h0, 1'b1, prof_out_t'{1'b1, 0, 0, 0, 0});
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b1, prof_out_t'{1'b1, 0, 0, 0, 0});
    add_item(REQ_RD_ARC, 32'h0, 32'h0, 12'h000, 1'b1,
             prof_out_t'{1'b0, 32'h0000_1000, 32'h0000_1020, 32'd1, 0});
    add_item(REQ_RD_HIST, 32'h0, 32'h0, 12'h008, 1'b1, prof_out_t'{1'b0, 0, 0, 0, 32'd1});
    // caller at the window top, entry past the table; callee wraps to all ones
    add_item(REQ_CALL, 32'h0000_510A, 32'h0000_000A, 12'h0, 1'b1, '0);
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b1, '0);
    add_item(REQ_CALL, 32'h0, 32'h0, 12'h0, 1'b1, '0);
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b1, '0);
    // last table entry; callee lands in the window but past the table
    add_item(REQ_CALL, 32'h0000_5007, 32'h0000_500B, 12'h0, 1'b1, prof_out_t'{1'b1, 0, 0, 0, 0});
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b1, '0);
    add_item(REQ_RD_ARC, 32'h0, 32'h0, 12'hFFF, 1'b1,
             prof_out_t'{1'b0, 32'h0000_4FFC, 32'h0000_5000, 32'd1, 0});
    add_item(REQ_CALL, 32'h0000_100A, 32'h0000_102B, 12'h0, 1'b0, '0);
    add_item(REQ_CALL, 32'h0000_100E, 32'h0000_100E, 12'h0, 1'b0, '0);
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b0, '0);
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b0, '0);
    add_item(REQ_RD_HIST, 32'h0, 32'h0, 12'h000, 1'b0, '0);
    add_item(REQ_RD_ARC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'h000, 1'b0, '0);
    // empty window
    add_cfg(1'b1, 32'h0000_8000, 32'h0000_7FFF);
    add_item(REQ_CALL, 32'h0000_800B, 32'h0000_800B, 12'h0, 1'b0, '0);
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b0, '0);
    // whole address space
    add_cfg(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    add_item(REQ_CALL, 32'h0000_000A, 32'h0000_000B, 12'h0, 1'b0, '0);
    add_item(REQ_TICK, 32'h0, 32'h0, 12'h0, 1'b0, '0);
    add_item(REQ_RD_HIST, 32'h0, 32'h0, 12'h000, 1'b0, '0);

    foreach (plan[r]) begin
      if (plan[r].cfg)
        set_window(plan[r].idx[0], plan[r].a, plan[r].b);
      else
        send_item(plan[r].kind, plan[r].a, plan[r].b, plan[r].idx, plan[r].pinned, plan[r].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      en    = 1'b1;
      burst = (ph == 2);
      case (ph)
        0: begin
          lo = $urandom_range(0, 32'hFFFF_0000);
          hi = lo + 32'(STEP * DEPTH) - 1;
        end
        2: begin
          lo = $urandom_range(0, 32'h8000_0000);
          hi = lo + 32'(STEP * DEPTH) + $urandom_range(4, 2048);
        end
        3: begin
          lo = '0;
          hi = '1;
        end
        4: begin
          lo = '1;
          hi = '1;
        end
        5: begin
          lo = $urandom | 32'h1;
          hi = $urandom_range(0, lo - 1);
        end
        default: begin
          en = (ph != 6);
          lo = $urandom_range(0, 32'hFFFF_FF00);
          hi = lo + 32'd255;
        end
      endcase
      set_window(en, lo, hi);
      hot_idx.delete();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) wait_drained();
        make_random_item(k, a, b, i);
        send_item(k, a, b, i, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("covered %0d calls, %0d ticks, %0d arc reads, %0d histogram reads, %0d recorded",
             n_kind[REQ_CALL], n_kind[REQ_TICK], n_kind[REQ_RD_ARC], n_kind[REQ_RD_HIST],
             n_recorded);
    $display("%0d register writes over %0d window settings, %0d mismatches",
             n_reg_writes, n_windows, mismatches);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
